>>> hw/rtl/crg_pkg.sv
package crg_pkg;

  localparam int MIN_RUN_WIDTH = 6;
  localparam logic [MIN_RUN_WIDTH-1:0] MIN_RUN_RESET = 6'd3;
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic can_push;
    logic has_data;
  } q_status_t;

endpackage

>>> hw/rtl/crg_queue.sv
module crg_queue #(
  parameter int WIDTH = 72
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [WIDTH-1:0]    push_data,
  input  logic                pop,
  output logic [WIDTH-1:0]    head_data,
  output crg_pkg::q_status_t  status
);

  localparam int PW = $clog2(crg_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(crg_pkg::QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slots [crg_pkg::QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    fill;

  always_comb begin
    status.can_push = (fill != CW'(crg_pkg::QUEUE_DEPTH));
    status.has_data = (fill != '0);
    head_data = slots[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + CW'(1);
      end else if (pop && !push) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

>>> hw/rtl/crg_front.sv
module crg_front #(
  parameter int VALUE_WIDTH = 32,
  parameter int MAX_MIN_RUN = 32,
  parameter int CW          = 6,
  parameter int CMD_W       = 2 * 32 + 6 + 2
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [crg_pkg::MIN_RUN_WIDTH-1:0] cfg_value,
  input  logic                              in_valid,
  input  logic [VALUE_WIDTH-1:0]            in_value,
  input  logic                              in_eos,
  output logic                              in_ready,
  input  crg_pkg::q_status_t                q_status,
  output logic                              q_push,
  output logic [CMD_W-1:0]                  q_data
);

  localparam int MW = crg_pkg::MIN_RUN_WIDTH;
  localparam logic [VALUE_WIDTH-1:0] MAX_POS = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

  logic [MW-1:0]          min_run;
  logic                   run_open;
  logic [VALUE_WIDTH-1:0] run_first;
  logic [VALUE_WIDTH-1:0] run_last;
  logic [CW-1:0]          run_count;
  logic                   pend_valid;
  logic [CMD_W-1:0]       pend_cmd;

  logic [MW-1:0]          need;
  logic                   accept;
  logic                   extend;
  logic                   close_a;
  logic [CMD_W-1:0]       cmd_a;
  logic [CMD_W-1:0]       cmd_b;
  logic [VALUE_WIDTH-1:0] first_next;
  logic [VALUE_WIDTH-1:0] last_next;
  logic [CW-1:0]          count_next;

  always_comb begin
    if (min_run == '0) begin
      need = MW'(1);
    end else if (min_run > MW'(MAX_MIN_RUN)) begin
      need = MW'(MAX_MIN_RUN);
    end else begin
      need = min_run;
    end

    in_ready = !pend_valid && q_status.can_push;
    accept   = in_valid && in_ready;
    extend   = run_open && (run_last != MAX_POS) && (in_value == run_last + VALUE_WIDTH'(1));
    close_a  = run_open && !extend;

    if (extend) begin
      first_next = run_first;
      last_next  = in_value;
      count_next = (run_count < CW'(MAX_MIN_RUN)) ? run_count + CW'(1) : run_count;
    end else begin
      first_next = in_value;
      last_next  = in_value;
      count_next = CW'(1);
    end

    cmd_a = {1'b0, (MW'(run_count) >= need), run_count, run_last, run_first};
    cmd_b = {1'b1, (MW'(count_next) >= need), count_next, last_next, first_next};

    q_push = 1'b0;
    q_data = cmd_a;
    if (pend_valid) begin
      q_push = q_status.can_push;
      q_data = pend_cmd;
    end else if (accept && close_a) begin
      q_push = 1'b1;
      q_data = cmd_a;
    end else if (accept && in_eos) begin
      q_push = 1'b1;
      q_data = cmd_b;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      run_first <= first_next;
      run_last  <= last_next;
      pend_cmd  <= cmd_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_run    <= crg_pkg::MIN_RUN_RESET;
      run_open   <= 1'b0;
      run_count  <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        min_run <= cfg_value;
      end
      if (pend_valid && q_status.can_push) begin
        pend_valid <= 1'b0;
      end
      if (accept) begin
        run_open   <= !in_eos;
        run_count  <= in_eos ? '0 : count_next;
        pend_valid <= in_eos && close_a;
      end
    end
  end

endmodule

>>> hw/rtl/crg_back.sv
module crg_back #(
  parameter int VALUE_WIDTH = 32,
  parameter int CW          = 6,
  parameter int CMD_W       = 2 * 32 + 6 + 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  crg_pkg::q_status_t         q_status,
  input  logic [CMD_W-1:0]           q_data,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_range,
  output logic [VALUE_WIDTH-1:0]     out_low,
  output logic [VALUE_WIDTH-1:0]     out_high,
  output logic                       out_final
);

  logic                   busy;
  logic [VALUE_WIDTH-1:0] cur;
  logic [VALUE_WIDTH-1:0] last;
  logic [CW-1:0]          remaining;
  logic                   as_range;
  logic                   final_cmd;

  logic adv;
  logic last_step;

  always_comb begin
    adv       = busy && (!out_valid || out_ready);
    last_step = as_range || (remaining == CW'(1));
    q_pop     = q_status.has_data && (!busy || (adv && last_step));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_range <= as_range;
      out_low   <= cur;
      out_high  <= as_range ? last : cur;
      out_final <= final_cmd && last_step;
    end
    if (q_pop) begin
      cur       <= q_data[VALUE_WIDTH-1:0];
      last      <= q_data[2*VALUE_WIDTH-1:VALUE_WIDTH];
      remaining <= q_data[2*VALUE_WIDTH+CW-1:2*VALUE_WIDTH];
      as_range  <= q_data[CMD_W-2];
      final_cmd <= q_data[CMD_W-1];
    end else if (adv) begin
      cur       <= cur + VALUE_WIDTH'(1);
      remaining <= remaining - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        busy <= 1'b1;
      end else if (adv && last_step) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/consecutive_run_grouper.sv
// Groups a stream of signed integers into runs of consecutive values (each one
// above the one before, no wrap at the top value). A run that closes, because a
// word breaks it or the stream ends, leaves as one range word when its length
// reaches min_run_length (0 acts as 1, values above MAX_MIN_RUN act as
// MAX_MIN_RUN); otherwise each member leaves as a single-value word in
// ascending order. tlast marks the last result word of the stream. The front
// takes one input word per cycle while the queue has room, and stalls for a
// held second command after a word that both breaks a run and ends the stream.
// Close commands pass through a four-entry queue to the back, which emits one
// word per cycle while m_tready is high: a range, or each value of a short run.
// Write min_run_length only while idle.
module consecutive_run_grouper #(
  parameter int VALUE_WIDTH = 32,
  parameter int MAX_MIN_RUN = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [crg_pkg::MIN_RUN_WIDTH-1:0]    cfg_data,  // min_run_length
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]     s_tdata,   // sample_value
  input  logic                                 s_tlast,   // end_of_stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [((2*VALUE_WIDTH+7)/8)*8-1:0]   m_tdata,   // low_value, high_value
  output logic                                 m_tuser,   // is_range
  output logic                                 m_tlast    // final_result
);

  localparam int OUT_W = ((2 * VALUE_WIDTH + 7) / 8) * 8;
  localparam int CW    = $clog2(MAX_MIN_RUN + 1);
  localparam int CMD_W = 2 * VALUE_WIDTH + CW + 2;

  crg_pkg::q_status_t     q_status;
  logic                   q_push;
  logic [CMD_W-1:0]       q_push_data;
  logic                   q_pop;
  logic [CMD_W-1:0]       q_head;
  logic [VALUE_WIDTH-1:0] out_low;
  logic [VALUE_WIDTH-1:0] out_high;

  assign cfg_ready = 1'b1;
  assign m_tdata   = OUT_W'({out_high, out_low});

  crg_front #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_MIN_RUN (MAX_MIN_RUN),
    .CW          (CW),
    .CMD_W       (CMD_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_value (cfg_data),
    .in_valid  (s_tvalid),
    .in_value  (s_tdata[VALUE_WIDTH-1:0]),
    .in_eos    (s_tlast),
    .in_ready  (s_tready),
    .q_status  (q_status),
    .q_push    (q_push),
    .q_data    (q_push_data)
  );

  crg_queue #(
    .WIDTH (CMD_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .head_data (q_head),
    .status    (q_status)
  );

  crg_back #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .CW          (CW),
    .CMD_W       (CMD_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .q_data    (q_head),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_range (m_tuser),
    .out_low   (out_low),
    .out_high  (out_high),
    .out_final (m_tlast)
  );

endmodule
